// ===== rtl/fdse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdse_pkg: shared types and constants of the Forth dual stack engine
// Command codes, request and reply beats, parameter defaults.
// ----------------------------------------------------------------------------
package fdse_pkg;

  localparam int VALUE_BITS       = 32;
  localparam int CMD_BITS         = 4;
  localparam int CELL_BITS_DEF    = 32;
  localparam int DATA_DEPTH_DEF   = 64;
  localparam int RETURN_DEPTH_DEF = 64;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CLEAR = 4'd0,
    CMD_DEPTH = 4'd1,
    CMD_DROP  = 4'd2,
    CMD_DUP   = 4'd3,
    CMD_OVER  = 4'd4,
    CMD_PEEK  = 4'd5,
    CMD_POP   = 4'd6,
    CMD_PUSH  = 4'd7,
    CMD_ROT   = 4'd8,
    CMD_SWAP  = 4'd9,
    CMD_TUCK  = 4'd10,
    CMD_ROLL  = 4'd11,
    CMD_RPUSH = 4'd12,
    CMD_RPOP  = 4'd13,
    CMD_RPEEK = 4'd14
  } cmd_e;

  typedef struct packed {
    logic [CMD_BITS-1:0]   command;
    logic [VALUE_BITS-1:0] push_value;
  } request_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] result_value;
    logic                  fault;
  } reply_t;

endpackage

// ===== rtl/fdse_cell_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdse_cell_ram: stack cell memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fdse_cell_ram #(
  parameter int WIDTH = fdse_pkg::CELL_BITS_DEF,
  parameter int DEPTH = fdse_pkg::DATA_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fdse_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdse_seq: command sequencer of the Forth dual stack engine
// Checks counts, reads stack cells, writes them back, steps through roll.
// ----------------------------------------------------------------------------
module fdse_seq #(
  parameter int CELL_BITS    = fdse_pkg::CELL_BITS_DEF,
  parameter int DATA_DEPTH   = fdse_pkg::DATA_DEPTH_DEF,
  parameter int RETURN_DEPTH = fdse_pkg::RETURN_DEPTH_DEF,
  localparam int DAW = $clog2(DATA_DEPTH),
  localparam int RAW = $clog2(RETURN_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  fdse_pkg::request_t   request,
  output logic                 busy,
  output logic                 done,
  output fdse_pkg::reply_t     reply,
  output logic                 d_we,
  output logic [DAW-1:0]       d_waddr,
  output logic [CELL_BITS-1:0] d_wdata,
  output logic [DAW-1:0]       d_raddr,
  input  logic [CELL_BITS-1:0] d_rdata,
  output logic                 r_we,
  output logic [RAW-1:0]       r_waddr,
  output logic [CELL_BITS-1:0] r_wdata,
  output logic [RAW-1:0]       r_raddr,
  input  logic [CELL_BITS-1:0] r_rdata
);

  localparam int DCW   = $clog2(DATA_DEPTH + 1);
  localparam int RCW   = $clog2(RETURN_DEPTH + 1);
  localparam int CMP_W = (CELL_BITS > DCW) ? CELL_BITS : DCW;
  localparam logic [DCW-1:0] D_FULL = DCW'(DATA_DEPTH);
  localparam logic [RCW-1:0] R_FULL = RCW'(RETURN_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_READ      = 8'b0000_0010,
    S_WRITE     = 8'b0000_0100,
    S_ROLL_CHK  = 8'b0000_1000,
    S_ROLL_T    = 8'b0001_0000,
    S_ROLL_SH   = 8'b0010_0000,
    S_ROLL_LAST = 8'b0100_0000,
    S_RREAD     = 8'b1000_0000
  } state_t;

  state_t                          state;
  logic [fdse_pkg::CMD_BITS-1:0]   cmd;
  logic [DCW-1:0]                  dcount;
  logic [RCW-1:0]                  rcount;
  logic [CELL_BITS-1:0]            t0, t1, t2;
  logic [1:0]                      step;
  logic [DAW-1:0]                  ptr;

  logic [CELL_BITS-1:0] pcell;
  logic [1:0]           need, nreads;
  logic                 grows, d_fault, r_empty, r_full, room;
  logic [DAW-1:0]       s0, s1, s2, top, rd_slot;
  logic [RCW-1:0]       rcount_m1;
  logic [CMP_W-1:0]     u_ext, n_m1, base_w;
  logic                 roll_bad, roll_zero, wr_last;

  // address of the cell k places below the top
  function automatic logic [DAW-1:0] slot_addr(input logic [DCW-1:0] cnt,
                                               input logic [1:0] k);
    logic [DCW-1:0] s;
    s = cnt - DCW'(k) - DCW'(1);
    return s[DAW-1:0];
  endfunction

  function automatic logic [1:0] need_items(input logic [fdse_pkg::CMD_BITS-1:0] c);
    logic [1:0] r;
    r = 2'd0;
    case (c) inside
      fdse_pkg::CMD_DROP, fdse_pkg::CMD_DUP, fdse_pkg::CMD_PEEK,
      fdse_pkg::CMD_POP, fdse_pkg::CMD_ROLL:                        r = 2'd1;
      fdse_pkg::CMD_OVER, fdse_pkg::CMD_SWAP, fdse_pkg::CMD_TUCK:   r = 2'd2;
      fdse_pkg::CMD_ROT:                                            r = 2'd3;
      default:                                                      r = 2'd0;
    endcase
    return r;
  endfunction

  assign pcell     = CELL_BITS'(request.push_value);
  assign need      = need_items(request.command);
  assign nreads    = need_items(cmd);
  assign grows     = (request.command == fdse_pkg::CMD_DUP) ||
                     (request.command == fdse_pkg::CMD_OVER) ||
                     (request.command == fdse_pkg::CMD_TUCK);
  assign room      = (dcount < D_FULL);
  assign d_fault   = (dcount < DCW'(need)) || (grows && !room);
  assign r_empty   = (rcount == '0);
  assign r_full    = (rcount >= R_FULL);
  assign rcount_m1 = rcount - RCW'(1);
  assign s0        = slot_addr(dcount, 2'd0);
  assign s1        = slot_addr(dcount, 2'd1);
  assign s2        = slot_addr(dcount, 2'd2);
  assign rd_slot   = slot_addr(dcount, step);
  assign top       = dcount[DAW-1:0];

  // roll count check and base address of the cell brought to the top
  assign u_ext     = CMP_W'(t0);
  assign n_m1      = CMP_W'(dcount) - CMP_W'(1);
  assign roll_bad  = (u_ext >= n_m1);
  assign roll_zero = (t0 == '0);
  assign base_w    = CMP_W'(dcount) - CMP_W'(2) - u_ext;

  assign wr_last   = (cmd == fdse_pkg::CMD_DUP) || (cmd == fdse_pkg::CMD_OVER) ||
                     ((cmd == fdse_pkg::CMD_SWAP) && (step == 2'd1)) ||
                     (step == 2'd2);

  assign busy = (state != S_IDLE);

  // memory port drive
  always_comb begin
    d_we    = 1'b0;
    d_waddr = top;
    d_wdata = pcell;
    d_raddr = s0;
    r_we    = 1'b0;
    r_waddr = rcount[RAW-1:0];
    r_wdata = pcell;
    r_raddr = rcount_m1[RAW-1:0];
    unique case (state)
      S_IDLE: begin
        if (start) begin
          d_we = (request.command == fdse_pkg::CMD_PUSH) && room;
          r_we = (request.command == fdse_pkg::CMD_RPUSH) && !r_full;
        end
      end
      S_READ: d_raddr = rd_slot;
      S_WRITE: begin
        d_we = 1'b1;
        unique case (cmd) inside
          fdse_pkg::CMD_DUP:  begin d_waddr = top; d_wdata = t0; end
          fdse_pkg::CMD_OVER: begin d_waddr = top; d_wdata = t1; end
          fdse_pkg::CMD_SWAP, fdse_pkg::CMD_TUCK: begin
            case (step)
              2'd0:    begin d_waddr = s1;  d_wdata = t0; end
              2'd1:    begin d_waddr = s0;  d_wdata = t1; end
              default: begin d_waddr = top; d_wdata = t0; end
            endcase
          end
          fdse_pkg::CMD_ROT: begin
            case (step)
              2'd0:    begin d_waddr = s2; d_wdata = t1; end
              2'd1:    begin d_waddr = s1; d_wdata = t0; end
              default: begin d_waddr = s0; d_wdata = t2; end
            endcase
          end
          default: d_we = 1'b0;
        endcase
      end
      S_ROLL_CHK: d_raddr = base_w[DAW-1:0];
      S_ROLL_T:   d_raddr = ptr + DAW'(1);
      S_ROLL_SH: begin
        d_we    = 1'b1;
        d_waddr = ptr;
        d_wdata = d_rdata;
        d_raddr = ptr + DAW'(2);
      end
      S_ROLL_LAST: begin
        d_we    = 1'b1;
        d_waddr = s0;
        d_wdata = t0;
      end
      S_RREAD: d_raddr = s0;
      default: d_raddr = s0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      dcount <= '0;
      rcount <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd  <= request.command;
            step <= 2'd1;
            reply.result_value <= '0;
            reply.fault        <= 1'b0;
            unique case (request.command) inside
              fdse_pkg::CMD_CLEAR: begin
                dcount <= '0;
                done   <= 1'b1;
              end
              fdse_pkg::CMD_DEPTH: begin
                reply.result_value <= fdse_pkg::VALUE_BITS'(dcount);
                done               <= 1'b1;
              end
              fdse_pkg::CMD_DROP: begin
                if (d_fault) reply.fault <= 1'b1;
                else dcount <= dcount - DCW'(1);
                done <= 1'b1;
              end
              fdse_pkg::CMD_PUSH: begin
                if (!room) reply.fault <= 1'b1;
                else dcount <= dcount + DCW'(1);
                done <= 1'b1;
              end
              fdse_pkg::CMD_RPUSH: begin
                if (r_full) reply.fault <= 1'b1;
                else rcount <= rcount + RCW'(1);
                done <= 1'b1;
              end
              fdse_pkg::CMD_RPOP, fdse_pkg::CMD_RPEEK: begin
                if (r_empty) begin
                  reply.fault <= 1'b1;
                  done        <= 1'b1;
                end else begin
                  state <= S_RREAD;
                end
              end
              fdse_pkg::CMD_DUP, fdse_pkg::CMD_OVER, fdse_pkg::CMD_PEEK,
              fdse_pkg::CMD_POP, fdse_pkg::CMD_ROT, fdse_pkg::CMD_SWAP,
              fdse_pkg::CMD_TUCK, fdse_pkg::CMD_ROLL: begin
                if (d_fault) begin
                  reply.fault <= 1'b1;
                  done        <= 1'b1;
                end else begin
                  state <= S_READ;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_READ: begin
          case (step)
            2'd1:    t0 <= d_rdata;
            2'd2:    t1 <= d_rdata;
            default: t2 <= d_rdata;
          endcase
          if (step < nreads) begin
            step <= step + 2'd1;
          end else begin
            step <= 2'd0;
            unique case (cmd) inside
              fdse_pkg::CMD_PEEK, fdse_pkg::CMD_POP: begin
                reply.result_value <= fdse_pkg::VALUE_BITS'(d_rdata);
                if (cmd == fdse_pkg::CMD_POP) dcount <= dcount - DCW'(1);
                done  <= 1'b1;
                state <= S_IDLE;
              end
              fdse_pkg::CMD_ROLL: state <= S_ROLL_CHK;
              default:            state <= S_WRITE;
            endcase
          end
        end
        S_WRITE: begin
          if (wr_last) begin
            if (cmd != fdse_pkg::CMD_SWAP && cmd != fdse_pkg::CMD_ROT) begin
              dcount <= dcount + DCW'(1);
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            step <= step + 2'd1;
          end
        end
        S_ROLL_CHK: begin
          if (roll_bad) begin
            reply.fault <= 1'b1;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            dcount <= dcount - DCW'(1);
            ptr    <= base_w[DAW-1:0];
            if (roll_zero) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_ROLL_T;
            end
          end
        end
        S_ROLL_T: begin
          t0    <= d_rdata;
          state <= S_ROLL_SH;
        end
        S_ROLL_SH: begin
          if (ptr + DAW'(1) == s0) state <= S_ROLL_LAST;
          else ptr <= ptr + DAW'(1);
        end
        S_ROLL_LAST: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_RREAD: begin
          reply.result_value <= fdse_pkg::VALUE_BITS'(r_rdata);
          if (cmd == fdse_pkg::CMD_RPOP) rcount <= rcount_m1;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/forth_dual_stack_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_dual_stack_engine: Forth data stack and return stack
// Runs one stack command per beat; each command gives exactly one reply beat.
// ----------------------------------------------------------------------------
//  channel   ports                     direction  handshake
//  --------  ------------------------  ---------  ---------------------------
//  request   start, busy, request      in         taken when start && !busy
//  reply     done, reply               out        one cycle strobe, no stall
//
//  Pacing: the single data memory, one read and one write per cycle, sets
//  the pace of the commands: cells go through it one by one, and roll moves
//  one cell a cycle.
//  Reset: synchronous rst empties both stacks; cell memories are not cleared.
//  Stalls: the receiver cannot stall; busy holds off new requests.
// ----------------------------------------------------------------------------
module forth_dual_stack_engine #(
  parameter int CELL_BITS    = fdse_pkg::CELL_BITS_DEF,
  parameter int DATA_DEPTH   = fdse_pkg::DATA_DEPTH_DEF,
  parameter int RETURN_DEPTH = fdse_pkg::RETURN_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  fdse_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output fdse_pkg::reply_t   reply
);

  localparam int DAW = $clog2(DATA_DEPTH);
  localparam int RAW = $clog2(RETURN_DEPTH);

  // data stack memory port
  logic                 d_we;
  logic [DAW-1:0]       d_waddr, d_raddr;
  logic [CELL_BITS-1:0] d_wdata, d_rdata;

  // return stack memory port
  logic                 r_we;
  logic [RAW-1:0]       r_waddr, r_raddr;
  logic [CELL_BITS-1:0] r_wdata, r_rdata;

  // Sequencer: decode the command, check depths, drive both memories.
  fdse_seq #(
    .CELL_BITS   (CELL_BITS),
    .DATA_DEPTH  (DATA_DEPTH),
    .RETURN_DEPTH(RETURN_DEPTH)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .reply  (reply),
    .d_we   (d_we),
    .d_waddr(d_waddr),
    .d_wdata(d_wdata),
    .d_raddr(d_raddr),
    .d_rdata(d_rdata),
    .r_we   (r_we),
    .r_waddr(r_waddr),
    .r_wdata(r_wdata),
    .r_raddr(r_raddr),
    .r_rdata(r_rdata)
  );

  // Data stack cells, slot 0 at the bottom.
  fdse_cell_ram #(
    .WIDTH(CELL_BITS),
    .DEPTH(DATA_DEPTH)
  ) u_data_ram (
    .clk  (clk),
    .we   (d_we),
    .waddr(d_waddr),
    .wdata(d_wdata),
    .raddr(d_raddr),
    .rdata(d_rdata)
  );

  // Return stack cells.
  fdse_cell_ram #(
    .WIDTH(CELL_BITS),
    .DEPTH(RETURN_DEPTH)
  ) u_return_ram (
    .clk  (clk),
    .we   (r_we),
    .waddr(r_waddr),
    .wdata(r_wdata),
    .raddr(r_raddr),
    .rdata(r_rdata)
  );

  // A faulted command yields a zero value.
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    done && reply.fault |-> reply.result_value == '0)
    else $error("fault reply carries a nonzero value");

  // Leaving a multi-cycle command always delivers its reply.
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("command finished without a reply");

  // Clear never faults and replies on the next cycle.
  a_clear_reply: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.command == fdse_pkg::CMD_CLEAR |=>
      done && !reply.fault)
    else $error("clear did not reply cleanly");

  // Reported depth never exceeds the data stack size.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.command == fdse_pkg::CMD_DEPTH |=>
      reply.result_value <= fdse_pkg::VALUE_BITS'(DATA_DEPTH))
    else $error("depth beyond stack size");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for forth_dual_stack_engine
// Drives command beats with random gaps and predicts each reply from a
// local model of the data and return stacks. Every reply beat is compared
// field by field against the oldest prediction. Covered: faults on empty
// stacks, every command, overflow on full stacks, deep and bad roll counts,
// then a long random mix that keeps both stacks at varied depths.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          DSTACK_SLOTS = fdse_pkg::DATA_DEPTH_DEF;
  localparam int          RSTACK_SLOTS = fdse_pkg::RETURN_DEPTH_DEF;
  localparam logic [3:0]  CMD_UNUSED   = 4'hF;
  localparam int          DRAIN_CYCLES = fdse_pkg::DATA_DEPTH_DEF + 16;

  logic               clk;
  logic               rst;
  logic               start;
  fdse_pkg::request_t request;
  logic               busy;
  logic               done;
  fdse_pkg::reply_t   reply;

  // Local copy of both stacks; slot 0 is the bottom.
  logic [31:0] dstack [DSTACK_SLOTS];
  logic [31:0] rstack [RSTACK_SLOTS];
  int          dcount;
  int          rcount;

  fdse_pkg::reply_t awaited_replies[$];
  int               fail_count;
  bit               gaps_on;

  forth_dual_stack_engine u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .reply   (reply)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one command to the local stacks and return the reply it yields.
  // A faulting command leaves both stacks as they were.
  function automatic fdse_pkg::reply_t run_stack_command(fdse_pkg::request_t req);
    fdse_pkg::reply_t r;
    logic [31:0]      t;
    logic [31:0]      a;
    logic [31:0]      b;
    logic [31:0]      u;
    int               n;
    int               m;
    int               k;
    int               j;
    bit               room;
    r    = '0;
    n    = dcount;
    room = n < DSTACK_SLOTS;
    case (req.command)
      fdse_pkg::CMD_CLEAR: dcount = 0;
      fdse_pkg::CMD_DEPTH: r.result_value = 32'(n);
      fdse_pkg::CMD_DROP: begin
        if (n < 1) r.fault = 1'b1;
        else dcount = n - 1;
      end
      fdse_pkg::CMD_DUP: begin
        if (n < 1 || !room) r.fault = 1'b1;
        else begin
          dstack[n] = dstack[n-1];
          dcount    = n + 1;
        end
      end
      fdse_pkg::CMD_OVER: begin
        if (n < 2 || !room) r.fault = 1'b1;
        else begin
          dstack[n] = dstack[n-2];
          dcount    = n + 1;
        end
      end
      fdse_pkg::CMD_PEEK: begin
        if (n < 1) r.fault = 1'b1;
        else r.result_value = dstack[n-1];
      end
      fdse_pkg::CMD_POP: begin
        if (n < 1) r.fault = 1'b1;
        else begin
          r.result_value = dstack[n-1];
          dcount         = n - 1;
        end
      end
      fdse_pkg::CMD_PUSH: begin
        if (!room) r.fault = 1'b1;
        else begin
          dstack[n] = req.push_value;
          dcount    = n + 1;
        end
      end
      fdse_pkg::CMD_ROT: begin
        if (n < 3) r.fault = 1'b1;
        else begin
          t           = dstack[n-3];
          dstack[n-3] = dstack[n-2];
          dstack[n-2] = dstack[n-1];
          dstack[n-1] = t;
        end
      end
      fdse_pkg::CMD_SWAP: begin
        if (n < 2) r.fault = 1'b1;
        else begin
          t           = dstack[n-2];
          dstack[n-2] = dstack[n-1];
          dstack[n-1] = t;
        end
      end
      fdse_pkg::CMD_TUCK: begin
        if (n < 2 || !room) r.fault = 1'b1;
        else begin
          a           = dstack[n-2];
          b           = dstack[n-1];
          dstack[n-2] = b;
          dstack[n-1] = a;
          dstack[n]   = b;
          dcount      = n + 1;
        end
      end
      fdse_pkg::CMD_ROLL: begin
        // Count comes off the top; it must index one of the items below it.
        if (n < 1) r.fault = 1'b1;
        else begin
          u = dstack[n-1];
          if (u >= 32'(n - 1)) r.fault = 1'b1;
          else begin
            m = n - 1;
            k = int'(u);
            t = dstack[m-1-k];
            for (j = k; j > 0; j--) dstack[m-1-j] = dstack[m-j];
            dstack[m-1] = t;
            dcount      = m;
          end
        end
      end
      fdse_pkg::CMD_RPUSH: begin
        if (rcount >= RSTACK_SLOTS) r.fault = 1'b1;
        else begin
          rstack[rcount] = req.push_value;
          rcount         = rcount + 1;
        end
      end
      fdse_pkg::CMD_RPOP: begin
        if (rcount < 1) r.fault = 1'b1;
        else begin
          rcount         = rcount - 1;
          r.result_value = rstack[rcount];
        end
      end
      fdse_pkg::CMD_RPEEK: begin
        if (rcount < 1) r.fault = 1'b1;
        else r.result_value = rstack[rcount-1];
      end
      default: ;
    endcase
    if (r.fault) r.result_value = '0;
    return r;
  endfunction

  // Send one command beat. Hold start and the payload until busy is low at
  // an edge, then record the predicted reply. Drop start only if a gap follows.
  task automatic send_command(input logic [3:0] cmd, input logic [31:0] value);
    fdse_pkg::request_t req;
    int                 gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.command    = cmd;
    req.push_value = value;
    request <= req;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    awaited_replies.push_back(run_stack_command(req));
  endtask

  function automatic logic [31:0] random_cell();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Every command but push and rpush on empty stacks, and the unused code: faults where an item is needed.
  task automatic test_empty_faults();
    send_command(fdse_pkg::CMD_CLEAR, 32'h0);
    send_command(fdse_pkg::CMD_DEPTH, 32'h0);
    send_command(fdse_pkg::CMD_DROP,  32'h0);
    send_command(fdse_pkg::CMD_DUP,   32'h0);
    send_command(fdse_pkg::CMD_OVER,  32'h0);
    send_command(fdse_pkg::CMD_PEEK,  32'h0);
    send_command(fdse_pkg::CMD_POP,   32'h0);
    send_command(fdse_pkg::CMD_ROT,   32'h0);
    send_command(fdse_pkg::CMD_SWAP,  32'h0);
    send_command(fdse_pkg::CMD_TUCK,  32'h0);
    send_command(fdse_pkg::CMD_ROLL,  32'h0);
    send_command(fdse_pkg::CMD_RPOP,  32'h0);
    send_command(fdse_pkg::CMD_RPEEK, 32'h0);
    send_command(CMD_UNUSED, 32'hFFFF_FFFF);
  endtask

  // Each command at least once with real data, roll at 1, 0 and a bad count.
  task automatic test_basic_ops();
    send_command(fdse_pkg::CMD_PUSH,  32'hFFFF_FFFF);
    send_command(fdse_pkg::CMD_PUSH,  32'h0000_0000);
    send_command(fdse_pkg::CMD_PUSH,  32'h5A5A_A5A5);
    send_command(fdse_pkg::CMD_ROT,   32'h0);
    send_command(fdse_pkg::CMD_SWAP,  32'h0);
    send_command(fdse_pkg::CMD_TUCK,  32'h0);
    send_command(fdse_pkg::CMD_OVER,  32'h0);
    send_command(fdse_pkg::CMD_DUP,   32'h0);
    send_command(fdse_pkg::CMD_PEEK,  32'h0);
    send_command(fdse_pkg::CMD_POP,   32'h0);
    send_command(fdse_pkg::CMD_PUSH,  32'h1);
    send_command(fdse_pkg::CMD_ROLL,  32'h0);
    send_command(fdse_pkg::CMD_PUSH,  32'h0);
    send_command(fdse_pkg::CMD_ROLL,  32'h0);
    send_command(fdse_pkg::CMD_PUSH,  32'd100);
    send_command(fdse_pkg::CMD_ROLL,  32'h0);
    send_command(fdse_pkg::CMD_DROP,  32'h0);
    send_command(fdse_pkg::CMD_DEPTH, 32'h0);
    send_command(fdse_pkg::CMD_RPUSH, 32'h0);
    send_command(fdse_pkg::CMD_RPUSH, 32'hFFFF_FFFF);
    send_command(fdse_pkg::CMD_RPEEK, 32'h0);
    send_command(fdse_pkg::CMD_RPOP,  32'h0);
    send_command(fdse_pkg::CMD_RPOP,  32'h0);
    send_command(fdse_pkg::CMD_CLEAR, 32'h0);
  endtask

  // Fill both stacks: overflow faults, the deepest legal roll, bad counts.
  task automatic test_full_stacks();
    while (dcount < DSTACK_SLOTS) send_command(fdse_pkg::CMD_PUSH, random_cell());
    send_command(fdse_pkg::CMD_DUP,   32'h0);
    send_command(fdse_pkg::CMD_OVER,  32'h0);
    send_command(fdse_pkg::CMD_PUSH,  32'hA5A5_5A5A);
    send_command(fdse_pkg::CMD_TUCK,  32'h0);
    send_command(fdse_pkg::CMD_DEPTH, 32'h0);
    send_command(fdse_pkg::CMD_DROP,  32'h0);
    send_command(fdse_pkg::CMD_PUSH,  32'(DSTACK_SLOTS - 2));
    send_command(fdse_pkg::CMD_ROLL,  32'h0);
    send_command(fdse_pkg::CMD_PUSH,  32'(DSTACK_SLOTS - 1));
    send_command(fdse_pkg::CMD_ROLL,  32'h0);
    send_command(fdse_pkg::CMD_DROP,  32'h0);
    send_command(fdse_pkg::CMD_PUSH,  32'hFFFF_FFFF);
    send_command(fdse_pkg::CMD_ROLL,  32'h0);
    send_command(fdse_pkg::CMD_CLEAR, 32'h0);
    while (rcount < RSTACK_SLOTS) send_command(fdse_pkg::CMD_RPUSH, random_cell());
    send_command(fdse_pkg::CMD_RPUSH, 32'h1234_5678);
    send_command(fdse_pkg::CMD_RPEEK, 32'h0);
    while (rcount > 0) send_command(fdse_pkg::CMD_RPOP, 32'h0);
  endtask

  // Random mix steered by the current depths so that both stacks wander
  // through shallow and deep states; roll comes as count push plus roll.
  task automatic test_random_mix(input int beats);
    int          i;
    int          pick;
    int          old_depth;
    logic [31:0] count;
    for (i = 0; i < beats; i++) begin
      if (i % 60 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 25 - (dcount > 40 ? 15 : 0) + (dcount < 4 ? 20 : 0)) begin
        send_command(fdse_pkg::CMD_PUSH, random_cell());
      end else if (pick < 40) begin
        old_depth = dcount;
        if (old_depth > 0 && $urandom_range(0, 7) != 0)
          count = 32'($urandom_range(0, old_depth - 1));
        else if ($urandom_range(0, 1) == 0)
          count = 32'(old_depth);
        else
          count = $urandom;
        send_command(fdse_pkg::CMD_PUSH, count);
        send_command(fdse_pkg::CMD_ROLL, 32'h0);
      end else if (pick < 50) begin
        if (rcount < RSTACK_SLOTS - 8 || $urandom_range(0, 3) == 0)
          send_command(fdse_pkg::CMD_RPUSH, random_cell());
        else
          send_command(fdse_pkg::CMD_RPOP, 32'h0);
      end else if (pick < 56) begin
        send_command(fdse_pkg::CMD_RPOP, 32'h0);
      end else if (pick < 59) begin
        send_command(fdse_pkg::CMD_RPEEK, 32'h0);
      end else if (pick < 62) begin
        // noise: any code, clear and the unused code included
        send_command(4'($urandom_range(0, 15)), $urandom);
      end else if (dcount > 40 && pick < 75) begin
        if ($urandom_range(0, 1) != 0) send_command(fdse_pkg::CMD_POP, 32'h0);
        else send_command(fdse_pkg::CMD_DROP, 32'h0);
      end else begin
        case ($urandom_range(0, 9))
          0: send_command(fdse_pkg::CMD_DEPTH, 32'h0);
          1: send_command(fdse_pkg::CMD_DROP,  32'h0);
          2: send_command(fdse_pkg::CMD_DUP,   32'h0);
          3: send_command(fdse_pkg::CMD_OVER,  32'h0);
          4: send_command(fdse_pkg::CMD_PEEK,  32'h0);
          5: send_command(fdse_pkg::CMD_POP,   32'h0);
          6: send_command(fdse_pkg::CMD_ROT,   32'h0);
          7: send_command(fdse_pkg::CMD_SWAP,  32'h0);
          8: send_command(fdse_pkg::CMD_TUCK,  32'h0);
          default: send_command(fdse_pkg::CMD_PEEK, 32'h0);
        endcase
      end
    end
  endtask

  // Each reply beat is on the ports for one cycle; take it at the edge.
  always @(posedge clk) begin : check_replies
    fdse_pkg::reply_t want;
    if (!rst && done) begin
      if (awaited_replies.size() == 0) begin
        $error("reply beat with no command outstanding: result_value %h fault %b",
               reply.result_value, reply.fault);
        fail_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (reply.result_value !== want.result_value) begin
          $error("result_value: expected %h, actual %h",
                 want.result_value, reply.result_value);
          fail_count++;
        end
        if (reply.fault !== want.fault) begin
          $error("fault: expected %b, actual %b", want.fault, reply.fault);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    dcount     = 0;
    rcount     = 0;
    fail_count = 0;
    gaps_on    = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_faults();
    test_basic_ops();
    test_full_stacks();
    test_random_mix(220);
    start <= 1'b0;

    // Drain outstanding replies, then watch for strays past the longest roll.
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("forth_dual_stack_engine verification clean");
    end else begin
      $display("forth_dual_stack_engine verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("forth_dual_stack_engine verification failed");
    $finish;
  end

endmodule
